// File: rtl/pft_pkg.sv
`timescale 1ns / 1ps

package pft_pkg;

   localparam int unsigned SlotW   = 41;
   localparam int unsigned FrameW  = 38;
   localparam int unsigned PredW   = 64;
   localparam int unsigned CountW  = 32;
   localparam int unsigned RotSpan = 48;
   localparam int unsigned AllocW  = 18;

   typedef enum logic [1:0] {
      UNIT_OTHER,
      UNIT_M,
      UNIT_B,
      UNIT_X
   } unit_type;

   typedef enum logic [3:0] {
      FOP_NONE,
      FOP_ALLOC,
      FOP_CALL,
      FOP_RET,
      FOP_RFI,
      FOP_COVER,
      FOP_LOOP,
      FOP_CLRRRB,
      FOP_CLRRRB_PR
   } frame_op_type;

   // Syllable mask and match pairs for the frame-changing instructions.
   localparam logic [SlotW-1:0] ALLOC_MASK     = 41'h1ee00000000;
   localparam logic [SlotW-1:0] ALLOC_MATCH    = 41'h02c00000000;
   localparam logic [SlotW-1:0] CALL_B_MASK    = 41'h16000000000;
   localparam logic [SlotW-1:0] CALL_B_MATCH   = 41'h02000000000;
   localparam logic [SlotW-1:0] CALL_X_MASK    = 41'h1c000000000;
   localparam logic [SlotW-1:0] CALL_X_MATCH   = 41'h18000000000;
   localparam logic [SlotW-1:0] RET_MASK       = 41'h1e1f80001c0;
   localparam logic [SlotW-1:0] RET_MATCH      = 41'h00108000100;
   localparam logic [SlotW-1:0] RFI_MASK       = 41'h1e1f0000000;
   localparam logic [SlotW-1:0] RFI_MATCH      = 41'h00040000000;
   localparam logic [SlotW-1:0] MISC_MASK      = 41'h1e1f8000000;
   localparam logic [SlotW-1:0] COVER_MATCH    = 41'h00010000000;
   localparam logic [SlotW-1:0] CLRRRB_MATCH   = 41'h00020000000;
   localparam logic [SlotW-1:0] CLRRRB_PR_MATCH = 41'h00028000000;
   localparam logic [SlotW-1:0] LOOP_MASK      = 41'h1e000000080;
   localparam logic [SlotW-1:0] LOOP_MATCH     = 41'h08000000080;

   localparam logic [5:0] LOOP_PRED = 6'd63;
   localparam logic [FrameW-1:0] FRAME_RESET = 38'd96;

   typedef struct packed {
      logic              wrong_path;
      frame_op_type      frame_op;
      logic [AllocW-1:0] alloc_bits;
      logic [5:0]        pred_reg_a;
      logic              pred_val_a;
      logic [5:0]        pred_reg_b;
      logic              pred_val_b;
      logic              move_all_preds;
      logic [PredW-1:0]  pred_image;
      logic [FrameW-1:0] trace_frame;
      logic              trace_frame_ok;
      logic              c1_missing;
   } item_type;

endpackage

// File: rtl/pft_ifs.sv
`timescale 1ns / 1ps

interface pft_req_if;
   logic                        valid;
   logic                        ready;
   logic                        wrong_path;
   logic [1:0]                  unit_kind;
   logic [pft_pkg::SlotW-1:0]   slot_bits;
   logic                        taken;
   logic [5:0]                  pred_reg_a;
   logic                        pred_val_a;
   logic [5:0]                  pred_reg_b;
   logic                        pred_val_b;
   logic                        move_all_preds;
   logic [pft_pkg::PredW-1:0]   pred_image;
   logic [pft_pkg::FrameW-1:0]  trace_frame;
   logic                        trace_frame_ok;

   modport source (
      output valid, wrong_path, unit_kind, slot_bits, taken, pred_reg_a, pred_val_a,
             pred_reg_b, pred_val_b, move_all_preds, pred_image, trace_frame,
             trace_frame_ok,
      input  ready
   );
   modport sink (
      input  valid, wrong_path, unit_kind, slot_bits, taken, pred_reg_a, pred_val_a,
             pred_reg_b, pred_val_b, move_all_preds, pred_image, trace_frame,
             trace_frame_ok,
      output ready
   );
endinterface

interface pft_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pft_pkg::PredW-1:0]   old_preds;
   logic [pft_pkg::PredW-1:0]   new_preds;
   logic [pft_pkg::FrameW-1:0]  old_frame;
   logic [pft_pkg::FrameW-1:0]  new_frame;
   logic                        is_warmup;
   logic                        squashed;
   logic                        frame_missing;
   logic                        c1_missing;

   modport source (
      output valid, old_preds, new_preds, old_frame, new_frame, is_warmup, squashed,
             frame_missing, c1_missing,
      input  ready
   );
   modport sink (
      input  valid, old_preds, new_preds, old_frame, new_frame, is_warmup, squashed,
             frame_missing, c1_missing,
      output ready
   );
endinterface

interface pft_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pft_pkg::CountW-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/pft_front.sv
`timescale 1ns / 1ps

module pft_front (
   pft_req_if.sink            req_if,
   output logic               push_valid,
   input  logic               push_ready,
   output pft_pkg::item_type  push_item
);

   pft_pkg::unit_type     unit;
   pft_pkg::frame_op_type fop;
   logic [pft_pkg::SlotW-1:0] s;

   assign unit = pft_pkg::unit_type'(req_if.unit_kind);
   assign s    = req_if.slot_bits;

   // Same priority as the decode chain: a non-taken call falls through to later tests.
   always_comb begin
      priority if (unit == pft_pkg::UNIT_M &&
                   (s & pft_pkg::ALLOC_MASK) == pft_pkg::ALLOC_MATCH) begin
         fop = pft_pkg::FOP_ALLOC;
      end else if (req_if.taken &&
                   ((unit == pft_pkg::UNIT_B &&
                     (s & pft_pkg::CALL_B_MASK) == pft_pkg::CALL_B_MATCH) ||
                    (unit == pft_pkg::UNIT_X &&
                     (s & pft_pkg::CALL_X_MASK) == pft_pkg::CALL_X_MATCH))) begin
         fop = pft_pkg::FOP_CALL;
      end else if (unit == pft_pkg::UNIT_B && req_if.taken &&
                   (s & pft_pkg::RET_MASK) == pft_pkg::RET_MATCH) begin
         fop = pft_pkg::FOP_RET;
      end else if (unit == pft_pkg::UNIT_B &&
                   (s & pft_pkg::RFI_MASK) == pft_pkg::RFI_MATCH) begin
         fop = pft_pkg::FOP_RFI;
      end else if (unit == pft_pkg::UNIT_B &&
                   (s & pft_pkg::MISC_MASK) == pft_pkg::COVER_MATCH) begin
         fop = pft_pkg::FOP_COVER;
      end else if (unit == pft_pkg::UNIT_B &&
                   (s & pft_pkg::LOOP_MASK) == pft_pkg::LOOP_MATCH) begin
         fop = pft_pkg::FOP_LOOP;
      end else if (unit == pft_pkg::UNIT_B &&
                   (s & pft_pkg::MISC_MASK) == pft_pkg::CLRRRB_MATCH) begin
         fop = pft_pkg::FOP_CLRRRB;
      end else if (unit == pft_pkg::UNIT_B &&
                   (s & pft_pkg::MISC_MASK) == pft_pkg::CLRRRB_PR_MATCH) begin
         fop = pft_pkg::FOP_CLRRRB_PR;
      end else begin
         fop = pft_pkg::FOP_NONE;
      end
   end

   always_comb begin
      push_item.wrong_path     = req_if.wrong_path;
      push_item.frame_op       = fop;
      // Rotating-region sizes and locals as they land in the low frame bits.
      push_item.alloc_bits     = {s[30:27], s[26:20], s[19:13]};
      push_item.pred_reg_a     = req_if.pred_reg_a;
      push_item.pred_val_a     = req_if.pred_val_a;
      push_item.pred_reg_b     = req_if.pred_reg_b;
      push_item.pred_val_b     = req_if.pred_val_b;
      push_item.move_all_preds = req_if.move_all_preds;
      push_item.pred_image     = req_if.pred_image;
      push_item.trace_frame    = req_if.trace_frame;
      push_item.trace_frame_ok = req_if.trace_frame_ok;
      push_item.c1_missing     = (req_if.pred_reg_a != pft_pkg::LOOP_PRED);
   end

   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

endmodule

// File: rtl/pft_queue.sv
`timescale 1ns / 1ps

module pft_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pft_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output pft_pkg::item_type  pop_item
);

   pft_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/pft_back.sv
`timescale 1ns / 1ps

module pft_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  pft_pkg::item_type  item,
   pft_csr_if.sink            csr_if,
   pft_rsp_if.source          rsp_if
);

   localparam logic [5:0] Span6 = 6'(pft_pkg::RotSpan);
   localparam logic [6:0] Span7 = 7'(pft_pkg::RotSpan);

   logic [pft_pkg::PredW-1:0]  pred_ff, pred_in;
   logic [pft_pkg::FrameW-1:0] frame_ff, frame_in;
   logic [pft_pkg::CountW-1:0] done_ff, done_in;
   logic [pft_pkg::CountW-1:0] limit_ff, limit_in;

   logic                       out_valid_ff, out_valid_in;
   logic [pft_pkg::PredW-1:0]  out_old_preds_ff, out_new_preds_ff;
   logic [pft_pkg::FrameW-1:0] out_old_frame_ff, out_new_frame_ff;
   logic                       out_warm_ff, out_squash_ff, out_fmiss_ff, out_c1_ff;

   logic                       fire;
   logic                       warm;
   logic [5:0]                 base;
   logic [5:0]                 phys_a, phys_b;
   logic [47:0]                img_hi;
   logic [95:0]                img_dbl;
   logic [pft_pkg::PredW-1:0]  upd_preds;
   logic [pft_pkg::FrameW-1:0] upd_frame;
   logic                       fmiss, c1miss;

   // Rename of a virtual predicate; p16..p63 rotate by the base within 48 entries.
   function automatic logic [5:0] phys_pred(input logic [5:0] v, input logic [5:0] b);
      logic [6:0] t;
      t = 7'({1'b0, v}) - 7'd16 + 7'({1'b0, b});
      if (t >= Span7) begin
         t = t - Span7;
      end
      if (v < 6'd16) begin
         return v;
      end
      return 6'(t + 7'd16);
   endfunction

   assign fire       = item_valid && (!out_valid_ff || rsp_if.ready);
   assign item_ready = !out_valid_ff || rsp_if.ready;
   assign warm       = (done_ff < limit_ff);

   assign base    = (frame_ff[37:32] >= Span6) ? frame_ff[37:32] - Span6 : frame_ff[37:32];
   assign phys_a  = phys_pred(item.pred_reg_a, base);
   assign phys_b  = phys_pred(item.pred_reg_b, base);
   assign img_hi  = item.pred_image[63:16];
   assign img_dbl = {img_hi, img_hi} << base;

   always_comb begin
      upd_preds = pred_ff;
      if (phys_a != 6'd0) begin
         upd_preds[phys_a] = item.pred_val_a;
      end
      if (phys_b != 6'd0) begin
         upd_preds[phys_b] = item.pred_val_b;
      end
      if (item.move_all_preds) begin
         upd_preds = {img_dbl[95:48], item.pred_image[15:1], pred_ff[0]};
      end
   end

   always_comb begin
      upd_frame = frame_ff;
      fmiss     = 1'b0;
      c1miss    = 1'b0;
      unique case (item.frame_op)
         pft_pkg::FOP_NONE: begin
            upd_frame = frame_ff;
         end
         pft_pkg::FOP_ALLOC: begin
            upd_frame = {frame_ff[37:18], item.alloc_bits};
         end
         pft_pkg::FOP_CALL: begin
            // New frame keeps only the outputs: sof minus sol.
            upd_frame = {31'd0, 7'(frame_ff[6:0] - frame_ff[13:7])};
         end
         pft_pkg::FOP_RET, pft_pkg::FOP_RFI: begin
            fmiss = !item.trace_frame_ok;
            if (item.trace_frame_ok) begin
               upd_frame = item.trace_frame;
            end
         end
         pft_pkg::FOP_COVER: begin
            upd_frame = '0;
         end
         pft_pkg::FOP_LOOP: begin
            c1miss = item.c1_missing;
            fmiss  = !item.trace_frame_ok;
            if (item.trace_frame_ok) begin
               upd_frame = item.trace_frame;
            end
         end
         pft_pkg::FOP_CLRRRB: begin
            upd_frame = {20'd0, frame_ff[17:0]};
         end
         pft_pkg::FOP_CLRRRB_PR: begin
            upd_frame = {6'd0, frame_ff[31:0]};
         end
         default: begin
            upd_frame = frame_ff;
         end
      endcase
      if (item.wrong_path) begin
         upd_frame = frame_ff;
         fmiss     = 1'b0;
         c1miss    = 1'b0;
      end
   end

   always_comb begin
      pred_in      = pred_ff;
      frame_in     = frame_ff;
      done_in      = done_ff;
      limit_in     = limit_ff;
      out_valid_in = out_valid_ff;
      if (csr_if.valid) begin
         limit_in = csr_if.data;
      end
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
         if (!item.wrong_path) begin
            pred_in  = upd_preds;
            frame_in = upd_frame;
            if (warm) begin
               done_in = done_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff      <= '1;
         frame_ff     <= pft_pkg::FRAME_RESET;
         done_ff      <= '0;
         limit_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pred_ff      <= pred_in;
         frame_ff     <= frame_in;
         done_ff      <= done_in;
         limit_ff     <= limit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_old_preds_ff <= pred_ff;
         out_new_preds_ff <= item.wrong_path ? pred_ff : upd_preds;
         out_old_frame_ff <= frame_ff;
         out_new_frame_ff <= upd_frame;
         out_warm_ff      <= warm;
         out_squash_ff    <= item.wrong_path;
         out_fmiss_ff     <= fmiss;
         out_c1_ff        <= c1miss;
      end
   end

   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.old_preds     = out_old_preds_ff;
   assign rsp_if.new_preds     = out_new_preds_ff;
   assign rsp_if.old_frame     = out_old_frame_ff;
   assign rsp_if.new_frame     = out_new_frame_ff;
   assign rsp_if.is_warmup     = out_warm_ff;
   assign rsp_if.squashed      = out_squash_ff;
   assign rsp_if.frame_missing = out_fmiss_ff;
   assign rsp_if.c1_missing    = out_c1_ff;

endmodule

// File: rtl/predicate_and_frame_tracker.sv
// A transaction accepted at the request side is written into the queue, and its result is
// registered at the back-end output when the back end takes the item from the queue.
// Throughput: one transaction per cycle while the result side is not stalled; the predicate
// file and frame update for an item is combinational and is registered as the item is taken.
// A two-entry queue between decode and execute absorbs result-side stalls.
// Reset (synchronous): predicate file all ones, frame 96, warm-up counter and limit zero.
`timescale 1ns / 1ps

module predicate_and_frame_tracker (
   input  logic       clock,
   input  logic       reset,
   pft_req_if.sink    req_if,
   pft_rsp_if.source  rsp_if,
   pft_csr_if.sink    csr_if
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   pft_pkg::item_type push_item, pop_item;

   pft_front u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   pft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .csr_if     (csr_if),
      .rsp_if     (rsp_if)
   );

   // A squashed transaction leaves all state untouched and raises no error.
   a_squash_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.squashed |->
         rsp_if.new_preds == rsp_if.old_preds && rsp_if.new_frame == rsp_if.old_frame &&
         !rsp_if.frame_missing && !rsp_if.c1_missing)
      else $error("squashed transaction changed state");

   // Predicate zero is never written.
   a_p0_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.new_preds[0] == rsp_if.old_preds[0])
      else $error("predicate zero changed");

   // A missing trace frame leaves the frame as it was.
   a_fmiss_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_missing |-> rsp_if.new_frame == rsp_if.old_frame)
      else $error("frame changed without a valid trace frame");

   // The queue only refuses new transactions while the back end holds a pending result.
   a_stall_only_backpressure: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> pop_valid && rsp_if.valid)
      else $error("queue full with an idle back end");

endmodule
